### rtl/imbb_pkg.sv
// shared types and constants for the indexed mesh bounding box
package imbb_pkg;

    // item kinds carried in the input tuser
    localparam logic OP_APPEND = 1'b0;
    localparam logic OP_INDEX  = 1'b1;

    // fixed field widths
    localparam int BASE_WIDTH  = 12;
    localparam int INDEX_WIDTH = 16;
    localparam int AXES        = 3;

    // control that travels with a store read into the accumulator
    typedef struct packed {
        logic valid;  // an index item is in this stage
        logic hit;    // slot was below the fill count
        logic last;   // closes the run
    } t_rd_ctl;

endpackage

### rtl/imbb_store.sv
// vertex store with fill count and registered index lookup
module imbb_store #(
    parameter int VERTEX_DEPTH = 4096,
    parameter int COORD_WIDTH  = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_valid,
    input  logic                                i_op,
    input  logic [3*COORD_WIDTH-1:0]            i_vertex,
    input  logic [imbb_pkg::INDEX_WIDTH-1:0]    i_index,
    input  logic                                i_has_index,
    input  logic                                i_last,
    input  logic [imbb_pkg::BASE_WIDTH-1:0]     i_base,
    output logic [3*COORD_WIDTH-1:0]            o_vertex,
    output imbb_pkg::t_rd_ctl                   o_ctl
);

    localparam int AW = $clog2(VERTEX_DEPTH);
    localparam int FW = AW + 1;
    localparam int SUM_W = imbb_pkg::INDEX_WIDTH + 1;
    localparam int SW = (FW > SUM_W) ? FW : SUM_W;

    logic [3*COORD_WIDTH-1:0] mem [VERTEX_DEPTH];
    logic [FW-1:0]            r_fill;
    logic [FW-1:0]            n_fill;
    logic [3*COORD_WIDTH-1:0] r_vertex;
    imbb_pkg::t_rd_ctl        r_ctl;
    imbb_pkg::t_rd_ctl        n_ctl;
    logic [SW-1:0]            slot;
    logic                     full;
    logic                     do_append;

    // slot address without wrap, and the full flag
    assign slot = SW'(i_base) + SW'(i_index);
    assign full = (r_fill == FW'(VERTEX_DEPTH));
    assign do_append = i_en && i_valid && (i_op == imbb_pkg::OP_APPEND) && !full;

    // fill count and lookup control
    always_comb begin
        n_fill = r_fill;
        if (do_append) begin
            n_fill = r_fill + FW'(1);
        end
        n_ctl.valid = i_valid && (i_op == imbb_pkg::OP_INDEX);
        n_ctl.hit   = i_has_index && (slot < SW'(r_fill));
        n_ctl.last  = i_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_ctl  <= '0;
        end else if (i_en) begin
            r_fill <= n_fill;
            r_ctl  <= n_ctl;
        end
    end

    // memory write on append, registered read on every advance
    always_ff @(posedge i_clk) begin
        if (do_append) begin
            mem[r_fill[AW-1:0]] <= i_vertex;
        end
        if (i_en) begin
            r_vertex <= mem[slot[AW-1:0]];
        end
    end

    assign o_vertex = r_vertex;
    assign o_ctl    = r_ctl;

endmodule

### rtl/imbb_accum.sv
// running per-axis min and max with result build on end of run
module imbb_accum #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic [3*COORD_WIDTH-1:0]            i_vertex,
    input  imbb_pkg::t_rd_ctl                   i_ctl,
    output logic                                o_res_valid,
    output logic [6*COORD_WIDTH:0]              o_res
);

    logic signed [COORD_WIDTH-1:0] r_lo [imbb_pkg::AXES];
    logic signed [COORD_WIDTH-1:0] r_hi [imbb_pkg::AXES];
    logic signed [COORD_WIDTH-1:0] n_lo [imbb_pkg::AXES];
    logic signed [COORD_WIDTH-1:0] n_hi [imbb_pkg::AXES];
    logic signed [COORD_WIDTH-1:0] upd_lo [imbb_pkg::AXES];
    logic signed [COORD_WIDTH-1:0] upd_hi [imbb_pkg::AXES];
    logic signed [COORD_WIDTH-1:0] p [imbb_pkg::AXES];
    logic                          r_seen;
    logic                          n_seen;
    logic                          upd_seen;
    logic                          take;
    logic                          emit;

    assign take = i_ctl.valid && i_ctl.hit;
    assign emit = i_ctl.valid && i_ctl.last;

    // fold the looked-up vertex into the bounds, then clear on end of run
    always_comb begin
        for (int a = 0; a < imbb_pkg::AXES; a++) begin
            p[a] = i_vertex[a*COORD_WIDTH +: COORD_WIDTH];
            upd_lo[a] = r_lo[a];
            upd_hi[a] = r_hi[a];
            if (take) begin
                if (!r_seen || (p[a] < r_lo[a])) begin
                    upd_lo[a] = p[a];
                end
                if (!r_seen || (p[a] > r_hi[a])) begin
                    upd_hi[a] = p[a];
                end
            end
            n_lo[a] = emit ? '0 : upd_lo[a];
            n_hi[a] = emit ? '0 : upd_hi[a];
        end
        upd_seen = r_seen || take;
        n_seen   = emit ? 1'b0 : upd_seen;
    end

    // result word: mins, maxes, seen flag from the low bit up
    always_comb begin
        o_res = '0;
        for (int a = 0; a < imbb_pkg::AXES; a++) begin
            o_res[a*COORD_WIDTH +: COORD_WIDTH]                   = upd_lo[a];
            o_res[(a+imbb_pkg::AXES)*COORD_WIDTH +: COORD_WIDTH]  = upd_hi[a];
        end
        o_res[6*COORD_WIDTH] = upd_seen;
    end
    assign o_res_valid = emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= 1'b0;
            for (int a = 0; a < imbb_pkg::AXES; a++) begin
                r_lo[a] <= '0;
                r_hi[a] <= '0;
            end
        end else if (i_en) begin
            r_seen <= n_seen;
            for (int a = 0; a < imbb_pkg::AXES; a++) begin
                r_lo[a] <= n_lo[a];
                r_hi[a] <= n_hi[a];
            end
        end
    end

endmodule

### rtl/indexed_mesh_bounding_box.sv
// Indexed mesh bounding box: append transfers (tuser 0) fill a vertex store in order,
// index transfers (tuser 1) look up store slot base + index and widen a per-axis
// min/max; a slot at or past the fill count is skipped and appends to a full store are
// dropped. An index transfer with tlast emits the bounds and a seen flag (all zero for
// an empty run) and clears the accumulator. One transfer is taken every clock cycle while
// the pipeline is not paused; an item goes through an input register and a registered store
// read, then the compare logic feeds the output register. The whole pipeline pauses only
// while a result sits unaccepted in the output register. The store needs no clearing.
module indexed_mesh_bounding_box #(
    parameter int VERTEX_DEPTH = 4096,
    parameter int COORD_WIDTH  = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [imbb_pkg::BASE_WIDTH-1:0]     i_cfg_wdata,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // vert_x, vert_y, vert_z, vertex_index, has_index, zero fill
    input  logic [((3*COORD_WIDTH+imbb_pkg::INDEX_WIDTH+1+7)/8)*8-1:0] s_axis_tdata,
    // op
    input  logic                                s_axis_tuser,
    input  logic                                s_axis_tlast,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // min_x, min_y, min_z, max_x, max_y, max_z, any_seen, zero fill
    output logic [((6*COORD_WIDTH+1+7)/8)*8-1:0] m_axis_tdata
);

    localparam int OUT_W = ((6*COORD_WIDTH+1+7)/8)*8;
    localparam int RES_W = 6*COORD_WIDTH + 1;
    localparam int IDX_LSB = 3*COORD_WIDTH;
    localparam int HAS_BIT = IDX_LSB + imbb_pkg::INDEX_WIDTH;

    logic                              en;
    logic [imbb_pkg::BASE_WIDTH-1:0]   r_base;
    logic                              r_s0_valid;
    logic                              r_s0_op;
    logic [3*COORD_WIDTH-1:0]          r_s0_vertex;
    logic [imbb_pkg::INDEX_WIDTH-1:0]  r_s0_index;
    logic                              r_s0_has;
    logic                              r_s0_last;
    logic [3*COORD_WIDTH-1:0]          rd_vertex;
    imbb_pkg::t_rd_ctl                 rd_ctl;
    logic                              res_valid;
    logic [RES_W-1:0]                  res;
    logic                              r_out_valid;
    logic [RES_W-1:0]                  r_out;

    // pipeline advances unless a result waits in the output register
    assign en = !r_out_valid || m_axis_tready;
    assign s_axis_tready = en;

    // base register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0;
        end else if (i_cfg_we) begin
            r_base <= i_cfg_wdata;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (en) begin
            r_s0_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s0_op     <= s_axis_tuser;
            r_s0_vertex <= s_axis_tdata[3*COORD_WIDTH-1:0];
            r_s0_index  <= s_axis_tdata[IDX_LSB +: imbb_pkg::INDEX_WIDTH];
            r_s0_has    <= s_axis_tdata[HAS_BIT];
            r_s0_last   <= s_axis_tlast;
        end
    end

    imbb_store #(
        .VERTEX_DEPTH (VERTEX_DEPTH),
        .COORD_WIDTH  (COORD_WIDTH)
    ) u_store (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_valid     (r_s0_valid),
        .i_op        (r_s0_op),
        .i_vertex    (r_s0_vertex),
        .i_index     (r_s0_index),
        .i_has_index (r_s0_has),
        .i_last      (r_s0_last),
        .i_base      (r_base),
        .o_vertex    (rd_vertex),
        .o_ctl       (rd_ctl)
    );

    imbb_accum #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_accum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_vertex    (rd_vertex),
        .i_ctl       (rd_ctl),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_W'(r_out);

endmodule

### tb/tb_indexed_mesh_bounding_box.sv
// self-checking testbench for the indexed mesh bounding box stream block
`timescale 1ns / 100ps

module tb_indexed_mesh_bounding_box;

    localparam int VERTEX_DEPTH      = 4096;
    localparam int COORD_W           = 16;
    localparam int BASE_W            = imbb_pkg::BASE_WIDTH;
    localparam int INDEX_W           = imbb_pkg::INDEX_WIDTH;
    localparam int IN_BITS           = 3*COORD_W + INDEX_W + 1;
    localparam int IN_W              = ((IN_BITS + 7)/8)*8;
    localparam int OUT_BITS          = 6*COORD_W + 1;
    localparam int OUT_W             = ((OUT_BITS + 7)/8)*8;
    localparam int CFG_SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES      = 12;
    localparam int WATCHDOG_LIMIT    = 4000;
    localparam int RUN_ITEMS_PER_PHASE = 36;
    localparam int NUM_PHASES        = 12;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idling_t;

    // one stored vertex, x in the lowest bits
    typedef struct packed {
        logic signed [COORD_W-1:0] z;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
    } vertex_t;

    // input tdata layout, vert_x in the lowest bits
    typedef struct packed {
        logic                      has_index;
        logic [INDEX_W-1:0]        vertex_index;
        logic signed [COORD_W-1:0] vert_z;
        logic signed [COORD_W-1:0] vert_y;
        logic signed [COORD_W-1:0] vert_x;
    } item_fields_t;

    // output tdata layout, min_x in the lowest bits
    typedef struct packed {
        logic                      any_seen;
        logic signed [COORD_W-1:0] max_z;
        logic signed [COORD_W-1:0] max_y;
        logic signed [COORD_W-1:0] max_x;
        logic signed [COORD_W-1:0] min_z;
        logic signed [COORD_W-1:0] min_y;
        logic signed [COORD_W-1:0] min_x;
    } bounds_t;

    // tracks the vertex store and the running box, holds the boxes still owed
    class bounds_tracker;
        vertex_t     slots [VERTEX_DEPTH];
        int unsigned fill;
        int unsigned base;
        vertex_t     low_corner;
        vertex_t     high_corner;
        bit          seen;
        bounds_t     pending_boxes [$];
        int unsigned errors;
        int unsigned boxes_checked;
        int unsigned transfers_in;

        function new();
            fill          = 0;
            base          = 0;
            low_corner    = '0;
            high_corner   = '0;
            seen          = 1'b0;
            errors        = 0;
            boxes_checked = 0;
            transfers_in  = 0;
        endfunction

        function void set_base(logic [BASE_W-1:0] value);
            base = value;
        endfunction

        function void take_item(logic op, item_fields_t f, logic last);
            int unsigned slot;
            vertex_t     v;
            bounds_t     box;
            transfers_in++;
            // appends fill the store in order and drop once it is full
            if (op == imbb_pkg::OP_APPEND) begin
                if (fill < VERTEX_DEPTH) begin
                    v.x = f.vert_x;
                    v.y = f.vert_y;
                    v.z = f.vert_z;
                    slots[fill] = v;
                    fill++;
                end
                return;
            end
            // slot is base plus index with no wrap, unfilled slots are skipped
            if (f.has_index) begin
                slot = base + f.vertex_index;
                if (slot < fill) begin
                    v = slots[slot];
                    if (!seen) begin
                        low_corner  = v;
                        high_corner = v;
                        seen        = 1'b1;
                    end else begin
                        if ($signed(v.x) < $signed(low_corner.x))  low_corner.x  = v.x;
                        if ($signed(v.y) < $signed(low_corner.y))  low_corner.y  = v.y;
                        if ($signed(v.z) < $signed(low_corner.z))  low_corner.z  = v.z;
                        if ($signed(v.x) > $signed(high_corner.x)) high_corner.x = v.x;
                        if ($signed(v.y) > $signed(high_corner.y)) high_corner.y = v.y;
                        if ($signed(v.z) > $signed(high_corner.z)) high_corner.z = v.z;
                    end
                end
            end
            // close the run, corners are still zero when nothing was seen
            if (last) begin
                box.min_x    = low_corner.x;
                box.min_y    = low_corner.y;
                box.min_z    = low_corner.z;
                box.max_x    = high_corner.x;
                box.max_y    = high_corner.y;
                box.max_z    = high_corner.z;
                box.any_seen = seen;
                pending_boxes.insert(pending_boxes.size(), box);
                low_corner  = '0;
                high_corner = '0;
                seen        = 1'b0;
            end
        endfunction

        function void compare_field(string name, int want, int got);
            if (want != got) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_bounds(logic [OUT_W-1:0] data);
            bounds_t want;
            bounds_t got;
            boxes_checked++;
            if (pending_boxes.size() == 0) begin
                $display("%0t: box transfer with none expected, expected nothing, actual %h",
                         $time, data);
                errors++;
                return;
            end
            want = pending_boxes.pop_front();
            got  = data[OUT_BITS-1:0];
            compare_field("min_x", $signed(want.min_x), $signed(got.min_x));
            compare_field("min_y", $signed(want.min_y), $signed(got.min_y));
            compare_field("min_z", $signed(want.min_z), $signed(got.min_z));
            compare_field("max_x", $signed(want.max_x), $signed(got.max_x));
            compare_field("max_y", $signed(want.max_y), $signed(got.max_y));
            compare_field("max_z", $signed(want.max_z), $signed(got.max_z));
            compare_field("any_seen", want.any_seen, got.any_seen);
            compare_field("tdata fill", 0, int'(data[OUT_W-1:OUT_BITS]));
        endfunction
    endclass

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               i_cfg_we      = 1'b0;
    logic [BASE_W-1:0]  i_cfg_wdata   = '0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    // vert_x, vert_y, vert_z, vertex_index, has_index, zero fill
    logic [IN_W-1:0]    s_axis_tdata  = '0;
    // op
    logic               s_axis_tuser  = 1'b0;
    logic               s_axis_tlast  = 1'b0;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    // min_x, min_y, min_z, max_x, max_y, max_z, any_seen, zero fill
    logic [OUT_W-1:0]   m_axis_tdata;

    bounds_tracker boxes = new();

    int unsigned src_idle_pct   = 0;
    int unsigned sink_stall_pct = 0;
    int unsigned stored_cnt     = 0;
    int unsigned cur_base       = 0;
    int unsigned sent_items     = 0;
    int unsigned base_writes    = 0;
    int unsigned quiet_cycles   = 0;

    indexed_mesh_bounding_box #(
        .VERTEX_DEPTH (VERTEX_DEPTH),
        .COORD_WIDTH  (COORD_W)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // receiver back-pressure
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // transfer monitor feeding the tracker
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we) begin
                boxes.set_base(i_cfg_wdata);
            end
            if (s_axis_tvalid && s_axis_tready) begin
                boxes.take_item(s_axis_tuser, s_axis_tdata[IN_BITS-1:0], s_axis_tlast);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                boxes.check_bounds(m_axis_tdata);
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || i_cfg_we) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no transfer for %0d cycles, %0d boxes still owed",
                         $time, quiet_cycles, boxes.pending_boxes.size());
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    task automatic set_idling(input idling_t mode);
        case (mode)
            IDLE_NONE: begin
                src_idle_pct = 0;  sink_stall_pct = 0;
            end
            IDLE_SENDER: begin
                src_idle_pct = 83; sink_stall_pct = 0;
            end
            IDLE_RECEIVER: begin
                src_idle_pct = 0;  sink_stall_pct = 83;
            end
            default: begin
                src_idle_pct = 14; sink_stall_pct = 14;
            end
        endcase
    endtask

    task automatic send_item(input logic op, input item_fields_t f, input logic last);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tlast  <= last;
        s_axis_tdata  <= {{(IN_W-IN_BITS){1'b0}}, f};
        do @(posedge i_clk); while (!s_axis_tready);
        sent_items++;
        if (op == imbb_pkg::OP_APPEND && stored_cnt < VERTEX_DEPTH) stored_cnt++;
    endtask

    function automatic item_fields_t random_fields();
        logic [95:0] r;
        r = {$urandom, $urandom, $urandom};
        return r[IN_BITS-1:0];
    endfunction

    // index fields and tlast are noise on an append
    task automatic send_append(input logic [COORD_W-1:0] x, y, z);
        item_fields_t f;
        f        = random_fields();
        f.vert_x = x;
        f.vert_y = y;
        f.vert_z = z;
        send_item(imbb_pkg::OP_APPEND, f, 1'($urandom_range(1)));
    endtask

    // coordinates are noise on an index item
    task automatic send_index(input logic [INDEX_W-1:0] idx, input logic has, input logic last);
        item_fields_t f;
        f              = random_fields();
        f.vertex_index = idx;
        f.has_index    = has;
        send_item(imbb_pkg::OP_INDEX, f, last);
    endtask

    function automatic logic [COORD_W-1:0] random_coord();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 10) return 16'h8000;
        if (r < 20) return 16'h7FFF;
        return 16'($urandom);
    endfunction

    task automatic send_random_append();
        send_append(random_coord(), random_coord(), random_coord());
    endtask

    // mostly filled slots, plus skipped slots, aliases and bare marks
    task automatic send_random_index(input logic last);
        int unsigned       r;
        int unsigned       reach;
        logic [INDEX_W-1:0] idx;
        logic              has;
        r   = $urandom_range(99);
        has = 1'b1;
        idx = 16'($urandom_range(16'hFFFF));
        if (r < 70 && stored_cnt > cur_base) begin
            idx = 16'($urandom_range(stored_cnt - 1 - cur_base));
        end else if (r < 78) begin
            has = 1'b0;
        end else if (r < 86 && cur_base > 0 && stored_cnt > 0) begin
            // low 16 bits of base + index hit a filled slot, the full sum does not
            reach = (cur_base < stored_cnt) ? cur_base : stored_cnt;
            idx   = 16'(32'h10000 - cur_base + $urandom_range(reach - 1));
        end else if (r < 92 && stored_cnt >= cur_base) begin
            idx = 16'(stored_cnt - cur_base + $urandom_range(2));
        end
        send_index(idx, has, last);
    endtask

    task automatic send_mesh_run();
        int n;
        n = $urandom_range(7);
        repeat (n) begin
            if ($urandom_range(99) < 8) send_random_append();
            else                        send_random_index(1'b0);
        end
        if ($urandom_range(99) < 15) send_index(16'($urandom_range(16'hFFFF)), 1'b0, 1'b1);
        else                         send_random_index(1'b1);
    endtask

    // base changes only once every owed box is out and the pipeline is empty
    task automatic write_base(input logic [BASE_W-1:0] value);
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (boxes.pending_boxes.size() != 0);
        repeat (CFG_SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cur_base = value;
        base_writes++;
    endtask

    initial begin
        int unsigned ph;
        int unsigned phase_start;
        logic [BASE_W-1:0] b;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty store, extremes, skips, read after write, base aliasing
        set_idling(IDLE_NONE);
        send_index(16'd0, 1'b1, 1'b1);
        send_index(16'd0, 1'b0, 1'b1);
        send_append(16'h8000, 16'h7FFF, 16'h0000);
        send_append(16'h7FFF, 16'h8000, 16'hFFFF);
        send_append(16'h0001, 16'hFFFF, 16'h8000);
        send_append(16'h0000, 16'h0000, 16'h7FFF);
        send_index(16'd0, 1'b1, 1'b0);
        send_index(16'd1, 1'b1, 1'b0);
        send_index(16'd2, 1'b1, 1'b0);
        send_index(16'd3, 1'b1, 1'b1);
        send_index(16'd2, 1'b1, 1'b1);
        send_index(16'd4, 1'b1, 1'b0);
        send_index(16'hFFFF, 1'b1, 1'b0);
        send_index(16'd1, 1'b0, 1'b0);
        send_index(16'd0, 1'b0, 1'b1);
        send_append(16'hFFFB, 16'h0007, 16'h0009);
        send_index(16'd4, 1'b1, 1'b1);
        send_index(16'd1, 1'b1, 1'b0);
        send_index(16'd3, 1'b1, 1'b1);
        write_base(12'd3);
        send_index(16'd0, 1'b1, 1'b0);
        send_index(16'hFFFF, 1'b1, 1'b0);
        send_index(16'hFFFD, 1'b1, 1'b0);
        send_index(16'd2, 1'b1, 1'b1);
        write_base(12'hFFF);
        send_index(16'd1, 1'b1, 1'b1);

        // random phases, each under its own idling pattern and base
        for (ph = 0; ph < NUM_PHASES; ph++) begin
            set_idling(idling_t'(ph % 4));
            if (ph == 0)                           b = '0;
            else if (ph == 5 || ph == 7 || ph == 11) b = '1;
            else if ($urandom_range(99) < 75 && stored_cnt > 0)
                b = BASE_W'($urandom_range(stored_cnt - 1));
            else
                b = BASE_W'($urandom_range(4095));
            write_base(b);
            repeat ($urandom_range(2, 12)) send_random_append();
            phase_start = sent_items;
            while (sent_items - phase_start < RUN_ITEMS_PER_PHASE) send_mesh_run();
        end

        // drain
        s_axis_tvalid <= 1'b0;
        while (boxes.pending_boxes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d input transfers and %0d bounding boxes, %0d base settings",
                 boxes.transfers_in, boxes.boxes_checked, base_writes);
        $display("vertex store reached %0d of %0d slots",
                 boxes.fill, VERTEX_DEPTH);
        if (boxes.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
